### sv/l3s_pkg.sv
// Package: shared types, constants and the Lanczos-3 coefficient table.
package l3s_pkg;

  localparam int MaxSourceWidth  = 256;
  localparam int MaxSourceHeight = 256;
  localparam int KernelRadius    = 3;
  localparam int PhaseSteps      = 256;
  localparam int Taps            = 2 * KernelRadius;
  localparam int RomSize         = KernelRadius * PhaseSteps;
  localparam int FrameDepth      = MaxSourceWidth * MaxSourceHeight;
  localparam int AddrW           = $clog2(FrameDepth);
  localparam int ColW            = $clog2(MaxSourceWidth);
  localparam int RowW            = $clog2(MaxSourceHeight);
  localparam int RomAddrW        = $clog2(RomSize);
  localparam int PixW            = 24;

  localparam longint unsigned PiQ30 = 64'd3373259426;

  // configuration register indexes
  localparam logic [1:0] CfgSourceWidth  = 2'd0;
  localparam logic [1:0] CfgSourceHeight = 2'd1;
  localparam logic [1:0] CfgHorizRatio   = 2'd2;
  localparam logic [1:0] CfgVertRatio    = 2'd3;

  typedef struct packed {
    logic        mode;
    logic [7:0]  in_red;
    logic [7:0]  in_green;
    logic [7:0]  in_blue;
    logic [11:0] out_column;
    logic [11:0] out_row;
  } req_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
  } res_t;

  // effective sizes (1..max) and ratios
  typedef struct packed {
    logic [8:0]  width;
    logic [8:0]  height;
    logic [24:0] hratio;
    logic [24:0] vratio;
  } cfg_t;

  // one tap issued by the sequencer to the MAC
  typedef struct packed {
    logic                valid;
    logic                vert;
    logic                first;
    logic                last;
    logic [2:0]          slot;
    logic                wzero;
    logic [RomAddrW-1:0] widx;
  } tap_t;

  typedef logic signed [15:0] coef_rom_t [RomSize];

  // unsigned 64-bit quotient by shift and subtract, table build only
  function automatic longint unsigned udiv64(longint unsigned n, longint unsigned d);
    longint unsigned q;
    longint unsigned r;
    q = 64'd0;
    r = 64'd0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], n[b]};
      if (r >= d) begin
        r    = r - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // sin(pi*m/den) in signed Q30, Taylor series
  function automatic longint sine_q30(longint unsigned m_in, longint unsigned den);
    longint unsigned m;
    longint unsigned a;
    longint unsigned term;
    longint          sum;
    logic            neg;
    m = m_in;
    while (m >= 2 * den) m = m - 2 * den;
    neg = 1'b0;
    if (m >= den) begin
      neg = 1'b1;
      m   = m - den;
    end
    if (2 * m > den) m = den - m;
    a    = udiv64(PiQ30 * m, den);
    term = a;
    sum  = longint'(a);
    for (int n = 1; n <= 10; n++) begin
      term = (term * a) >> 30;
      term = (term * a) >> 30;
      term = udiv64(term, longint'((2 * n) * (2 * n + 1)));
      if ((n & 1) == 1) sum = sum - longint'(term);
      else              sum = sum + longint'(term);
    end
    return neg ? -sum : sum;
  endfunction

  function automatic coef_rom_t build_coef_rom();
    coef_rom_t       rom;
    longint          s1;
    longint          s2;
    logic            neg;
    longint unsigned m1;
    longint unsigned m2;
    longint unsigned prod;
    longint unsigned x22;
    longint unsigned den;
    longint unsigned num;
    longint unsigned v;
    rom[0] = 16'sd16384;
    for (int k = 1; k < RomSize; k++) begin
      s1   = sine_q30(longint'(k), longint'(PhaseSteps));
      s2   = sine_q30(longint'(k), longint'(PhaseSteps * KernelRadius));
      neg  = (s1 < 0) != (s2 < 0);
      m1   = longint'(s1 < 0 ? -s1 : s1);
      m2   = longint'(s2 < 0 ? -s2 : s2);
      prod = (m1 * m2) >> 30;
      x22  = udiv64(PiQ30 * longint'(k), longint'(PhaseSteps * 256));
      den  = x22 * x22;
      num  = longint'(KernelRadius) * prod * (64'd1 << 28);
      v    = udiv64(num + (den >> 1), den);
      rom[k] = neg ? -16'(v) : 16'(v);
    end
    return rom;
  endfunction

  localparam coef_rom_t CoefRom = build_coef_rom();

endpackage

### sv/lanczos3_image_scaler_core.sv
// Top level: separable Lanczos-3 RGB scaler with frame store.
//
//  channel  | signals                          | direction | transfer
//  ---------+----------------------------------+-----------+---------------------------
//  request  | start_i, req_i, busy_o           | in        | start_i && !busy_o
//  result   | res_valid_o, res_o               | out       | res_valid_o, one cycle
//  config   | cfg_we_i, cfg_idx_i, cfg_data_i  | in        | cfg_we_i
//
// A load (mode 0) writes the frame store in the transfer cycle; busy stays low.
// A request (mode 1) holds busy through 2 position multiplies,
// 36 horizontal taps at one frame store read per cycle, a drain wait,
// 6 vertical taps and the MAC pipeline tail. The single read port sets this pace.
// rst_ni clears control and config; the frame store is not cleared.
// The result has no back-pressure: res_valid_o pulses for one cycle.
module lanczos3_image_scaler_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  l3s_pkg::req_t  req_i,
  output logic           busy_o,
  output logic           res_valid_o,
  output l3s_pkg::res_t  res_o,
  input  logic           cfg_we_i,
  input  logic [1:0]     cfg_idx_i,
  input  logic [24:0]    cfg_data_i
);

  logic [8:0]  width_q, height_q;
  logic [24:0] hratio_q, vratio_q;
  l3s_pkg::cfg_t cfg;
  logic        accept, load, req, size_wr;
  logic [l3s_pkg::AddrW-1:0] load_addr, rd_addr;
  logic [l3s_pkg::PixW-1:0]  rdata, mac_res;
  l3s_pkg::tap_t tap;
  logic        done;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 9'd256;
      height_q <= 9'd256;
      hratio_q <= 25'd65536;
      vratio_q <= 25'd65536;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        l3s_pkg::CfgSourceWidth:  width_q  <= cfg_data_i[8:0];
        l3s_pkg::CfgSourceHeight: height_q <= cfg_data_i[8:0];
        l3s_pkg::CfgHorizRatio:   hratio_q <= cfg_data_i;
        l3s_pkg::CfgVertRatio:    vratio_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // zero size acts as one, oversize as the maximum
  always_comb begin
    cfg.width  = (width_q == 9'd0) ? 9'd1 :
                 (width_q > 9'(l3s_pkg::MaxSourceWidth)) ? 9'(l3s_pkg::MaxSourceWidth) :
                 width_q;
    cfg.height = (height_q == 9'd0) ? 9'd1 :
                 (height_q > 9'(l3s_pkg::MaxSourceHeight)) ? 9'(l3s_pkg::MaxSourceHeight) :
                 height_q;
    cfg.hratio = hratio_q;
    cfg.vratio = vratio_q;
  end

  assign accept  = start_i && !busy_o;
  assign load    = accept && !req_i.mode;
  assign req     = accept && req_i.mode;
  assign size_wr = cfg_we_i && (cfg_idx_i == l3s_pkg::CfgSourceWidth ||
                                cfg_idx_i == l3s_pkg::CfgSourceHeight);

  l3s_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .size_wr_i   (size_wr),
    .load_i      (load),
    .req_i       (req),
    .col_i       (req_i.out_column),
    .row_i       (req_i.out_row),
    .done_i      (done),
    .busy_o      (busy_o),
    .load_addr_o (load_addr),
    .rd_addr_o   (rd_addr),
    .tap_o       (tap)
  );

  // frame store, red in the top byte
  l3s_ram #(
    .Width (l3s_pkg::PixW),
    .Depth (l3s_pkg::FrameDepth)
  ) u_frame (
    .clk_i   (clk_i),
    .we_i    (load),
    .waddr_i (load_addr),
    .wdata_i ({req_i.in_red, req_i.in_green, req_i.in_blue}),
    .raddr_i (rd_addr),
    .rdata_o (rdata)
  );

  l3s_mac u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tap_i       (tap),
    .ram_rdata_i (rdata),
    .res_o       (mac_res),
    .done_o      (done)
  );

  assign res_valid_o     = done;
  assign res_o.out_red   = mac_res[23:16];
  assign res_o.out_green = mac_res[15:8];
  assign res_o.out_blue  = mac_res[7:0];

  // a result only ends a request in progress
  assert property (@(posedge clk_i) disable iff (!rst_ni) res_valid_o |-> busy_o)
    else $error("result strobe while idle");

  // a request transfer starts the sequencer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && req_i.mode) |=> busy_o)
    else $error("request did not raise busy");

  // a load never occupies the block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && !req_i.mode) |=> !busy_o)
    else $error("load raised busy");

endmodule

### sv/l3s_ram.sv
// Generic single-write, single-read RAM with registered read data.
module l3s_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end

endmodule

### sv/l3s_mac.sv
// Shared tap unit: coefficient lookup, per-channel multiply, accumulate, clamp, row partials.
module l3s_mac (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  l3s_pkg::tap_t            tap_i,
  input  logic [l3s_pkg::PixW-1:0] ram_rdata_i,
  output logic [l3s_pkg::PixW-1:0] res_o,
  output logic                     done_o
);

  l3s_pkg::tap_t              c1_q, c2_q;
  logic signed [15:0]         w1_q;
  logic [l3s_pkg::PixW-1:0]   part1_q;
  logic [l3s_pkg::PixW-1:0]   parts_q [l3s_pkg::Taps];
  logic [l3s_pkg::PixW-1:0]   pix;
  logic signed [10:0]         prod_d [3];
  logic signed [10:0]         prod_q [3];
  logic signed [12:0]         acc_q  [3];
  logic signed [12:0]         acc_d  [3];
  logic [l3s_pkg::PixW-1:0]   res_q;
  logic                       rv_q, rvert_q;
  logic [2:0]                 rslot_q;
  logic [l3s_pkg::PixW-1:0]   clamp_d;

  // stage 1: coefficient and partial fetch
  always_ff @(posedge clk_i) begin
    w1_q    <= tap_i.wzero ? 16'sd0 : l3s_pkg::CoefRom[tap_i.widx];
    part1_q <= parts_q[tap_i.slot];
  end

  // stage 2: products, truncated toward zero
  always_comb begin
    logic signed [24:0] p;
    pix = c1_q.vert ? part1_q : ram_rdata_i;
    for (int c = 0; c < 3; c++) begin
      p = $signed({1'b0, pix[16-8*c +: 8]}) * w1_q;
      if (p < 0) prod_d[c] = 11'((p + 25'sd16383) >>> 14);
      else       prod_d[c] = 11'(p >>> 14);
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  // stage 3: accumulate and clamp
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      acc_d[c] = (c2_q.first ? 13'sd0 : acc_q[c]) + 13'(prod_q[c]);
      if (acc_d[c] < 0)            clamp_d[16-8*c +: 8] = 8'd0;
      else if (acc_d[c] > 13'sd255) clamp_d[16-8*c +: 8] = 8'd255;
      else                          clamp_d[16-8*c +: 8] = acc_d[c][7:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (c2_q.valid) acc_q <= acc_d;
    if (c2_q.valid && c2_q.last) begin
      res_q   <= clamp_d;
      rslot_q <= c2_q.slot;
    end
    if (rv_q && !rvert_q) parts_q[rslot_q] <= res_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_q    <= '0;
      c2_q    <= '0;
      rv_q    <= 1'b0;
      rvert_q <= 1'b0;
    end else begin
      c1_q    <= tap_i;
      c2_q    <= c1_q;
      rv_q    <= c2_q.valid && c2_q.last;
      rvert_q <= c2_q.vert;
    end
  end

  assign res_o  = res_q;
  assign done_o = rv_q && rvert_q;

endmodule

### sv/l3s_seq.sv
// Sequencer: source positions, tap addressing, load pointer.
module l3s_seq (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  l3s_pkg::cfg_t             cfg_i,
  input  logic                      size_wr_i,
  input  logic                      load_i,
  input  logic                      req_i,
  input  logic [11:0]               col_i,
  input  logic [11:0]               row_i,
  input  logic                      done_i,
  output logic                      busy_o,
  output logic [l3s_pkg::AddrW-1:0] load_addr_o,
  output logic [l3s_pkg::AddrW-1:0] rd_addr_o,
  output l3s_pkg::tap_t             tap_o
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StPosX  = 3'd1;
  localparam logic [2:0] StPosY  = 3'd2;
  localparam logic [2:0] StHRun  = 3'd3;
  localparam logic [2:0] StHWait = 3'd4;
  localparam logic [2:0] StVRun  = 3'd5;
  localparam logic [2:0] StFin   = 3'd6;

  logic [2:0]  state_q, state_d;
  logic [2:0]  i_q, i_d, j_q, j_d;
  logic [1:0]  wait_q, wait_d;
  logic [11:0] col_q, row_q;
  logic [20:0] ipx_q, ipy_q;
  logic signed [16:0] remx_q, remy_q;
  logic [l3s_pkg::AddrW-1:0] lpos_q;
  logic [16:0] lnext, fsize;

  // shared position multiplier: (2o+1)*ratio
  logic [12:0] mo;
  logic [24:0] mr;
  logic [37:0] mprod;
  logic signed [38:0] p17, pos;
  logic [20:0] ip_d;
  logic signed [16:0] rem_d;

  always_comb begin
    mo    = (state_q == StPosY) ? {row_q, 1'b1} : {col_q, 1'b1};
    mr    = (state_q == StPosY) ? cfg_i.vratio : cfg_i.hratio;
    mprod = 38'(mo) * 38'(mr);
    p17   = $signed({1'b0, mprod}) - 39'sd65536;
    pos   = (p17 < 0) ? ((p17 + 39'sd1) >>> 1) : (p17 >>> 1);
    ip_d  = (pos < 0) ? 21'd0 : pos[36:16];
    rem_d = (pos < 0) ? pos[16:0] : $signed({1'b0, pos[15:0]});
  end

  function automatic logic [7:0] clamp_idx(logic [20:0] ip, logic [2:0] off,
                                           logic [8:0] lim);
    logic signed [22:0] t;
    t = $signed({2'b0, ip}) + $signed({20'b0, off}) - 23'sd2;
    if (t < 0)                         return 8'd0;
    else if (t >= $signed({14'b0, lim})) return 8'(lim - 9'd1);
    else                               return t[7:0];
  endfunction

  function automatic logic [10:0] wt_idx(logic signed [16:0] rem, logic [2:0] off);
    logic signed [19:0] d;
    logic [18:0]        ad;
    d  = $signed({{3{rem[16]}}, rem}) + 20'sd131072 - $signed({1'b0, off, 16'b0});
    ad = (d < 0) ? 19'(-d) : 19'(d);
    return ad[18:8];
  endfunction

  logic [7:0]  tcol, trow;
  logic [10:0] widx;

  always_comb begin
    tcol  = clamp_idx(ipx_q, i_q, cfg_i.width);
    trow  = clamp_idx(ipy_q, j_q, cfg_i.height);
    widx  = (state_q == StVRun) ? wt_idx(remy_q, i_q) : wt_idx(remx_q, i_q);
    rd_addr_o = l3s_pkg::AddrW'(17'(trow) * 17'(cfg_i.width) + 17'(tcol));
    tap_o.valid = (state_q == StHRun) || (state_q == StVRun);
    tap_o.vert  = (state_q == StVRun);
    tap_o.first = (i_q == 3'd0);
    tap_o.last  = (i_q == 3'(l3s_pkg::Taps - 1));
    tap_o.slot  = (state_q == StVRun) ? i_q : j_q;
    tap_o.wzero = (widx >= 11'(l3s_pkg::RomSize));
    tap_o.widx  = widx[l3s_pkg::RomAddrW-1:0];
  end

  always_comb begin
    state_d = state_q;
    i_d     = i_q;
    j_d     = j_q;
    wait_d  = wait_q;
    case (state_q)
      StIdle: if (req_i) state_d = StPosX;
      StPosX: state_d = StPosY;
      StPosY: begin
        state_d = StHRun;
        i_d     = 3'd0;
        j_d     = 3'd0;
      end
      StHRun: begin
        if (i_q == 3'(l3s_pkg::Taps - 1)) begin
          i_d = 3'd0;
          j_d = j_q + 3'd1;
          if (j_q == 3'(l3s_pkg::Taps - 1)) begin
            state_d = StHWait;
            wait_d  = 2'd0;
          end
        end else begin
          i_d = i_q + 3'd1;
        end
      end
      StHWait: begin
        wait_d = wait_q + 2'd1;
        if (wait_q == 2'd2) state_d = StVRun;
      end
      StVRun: begin
        i_d = i_q + 3'd1;
        if (i_q == 3'(l3s_pkg::Taps - 1)) state_d = StFin;
      end
      StFin: if (done_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      i_q     <= 3'd0;
      j_q     <= 3'd0;
      wait_q  <= 2'd0;
      lpos_q  <= '0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      wait_q  <= wait_d;
      if (size_wr_i)  lpos_q <= '0;
      else if (load_i) lpos_q <= (lnext >= fsize) ? '0 : lnext[l3s_pkg::AddrW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i) begin
      col_q <= col_i;
      row_q <= row_i;
    end
    if (state_q == StPosX) begin
      ipx_q  <= ip_d;
      remx_q <= rem_d;
    end
    if (state_q == StPosY) begin
      ipy_q  <= ip_d;
      remy_q <= rem_d;
    end
  end

  assign lnext       = 17'(lpos_q) + 17'd1;
  assign fsize       = 17'(18'(cfg_i.width) * 18'(cfg_i.height));
  assign load_addr_o = lpos_q;
  assign busy_o      = (state_q != StIdle);

endmodule

### test/testbench.sv
// Testbench for the Lanczos-3 image scaler core: directed table, random phases, predictor.
`timescale 1ns / 1ps

module testbench;

  localparam int  ClkHalf     = 4;
  localparam int  DrainCycles = 60;
  localparam int  CycleLimit  = 2000000;
  localparam int  RandItems   = 1900;
  localparam int  TapCount    = 6;
  localparam int  CoefCount   = 768;      // three units of 256 phases each

  typedef enum logic [1:0] {RowCfg, RowLoad, RowReq} row_kind_e;

  // one line of the directed table
  typedef struct packed {
    row_kind_e      kind;
    logic [1:0]     idx;
    logic [24:0]    value;
    l3s_pkg::req_t  req;
    logic           typed;   // expected pixel given in the table
    l3s_pkg::res_t  want;
  } stim_row_t;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          start_i = 1'b0;
  l3s_pkg::req_t req_i = '0;
  logic          busy_o;
  logic          res_valid_o;
  l3s_pkg::res_t res_o;
  logic          cfg_we_i = 1'b0;
  logic [1:0]    cfg_idx_i = '0;
  logic [24:0]   cfg_data_i = '0;

  lanczos3_image_scaler_core dut (
    .clk_i, .rst_ni, .start_i, .req_i, .busy_o, .res_valid_o, .res_o,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  always #ClkHalf clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Predictor state: own copy of the frame store, load pointer and registers.
  // ---------------------------------------------------------------------------
  logic [23:0] frame_mem [65536];
  int unsigned load_ptr;
  logic [8:0]  width_reg, height_reg;
  logic [24:0] hratio_reg, vratio_reg;
  int          lanczos_coef [CoefCount];

  l3s_pkg::res_t pixels_due [$];   // resampled pixels still to arrive
  int          err_count;
  int          cycle_count;
  int          req_count, load_count, cfg_count;
  bit          idle_on;          // random idling enabled

  // sin(pi*m/den) in Q30 by a Taylor series, integer only
  function automatic longint sin_pi_q30(longint unsigned m, longint unsigned den);
    longint unsigned a, term;
    longint          acc;
    bit              negate;
    negate = 1'b0;
    m = m % (2 * den);
    if (m >= den) begin
      negate = 1'b1;
      m = m - den;
    end
    if (2 * m > den) m = den - m;
    a = 64'd3373259426 * m / den;
    term = a;
    acc = longint'(a);
    for (int n = 1; n <= 10; n++) begin
      term = (term * a) >> 30;
      term = (term * a) >> 30;
      term = term / longint'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) acc = acc - longint'(term);
      else acc = acc + longint'(term);
    end
    return negate ? -acc : acc;
  endfunction

  // kernel table in Q2.14: 3 * sin(pi x) sin(pi x / 3) / (pi x)^2
  task automatic fill_lanczos_coef();
    longint          s1, s2;
    longint unsigned m1, m2, prod, x22, den, num;
    int              v;
    bit              neg;
    lanczos_coef[0] = 16384;
    for (int k = 1; k < CoefCount; k++) begin
      s1 = sin_pi_q30(k, 256);
      s2 = sin_pi_q30(k, 768);
      neg = (s1 < 0) != (s2 < 0);
      m1 = s1 < 0 ? -s1 : s1;
      m2 = s2 < 0 ? -s2 : s2;
      prod = (m1 * m2) >> 30;
      x22 = 64'd3373259426 * k / 65536;
      den = x22 * x22;
      num = 3 * prod * (64'd1 << 28);
      v = int'((num + den / 2) / den);
      lanczos_coef[k] = neg ? -v : v;
    end
  endtask

  function automatic int eff_width();
    return width_reg == 0 ? 1 : (width_reg > 256 ? 256 : int'(width_reg));
  endfunction

  function automatic int eff_height();
    return height_reg == 0 ? 1 : (height_reg > 256 ? 256 : int'(height_reg));
  endfunction

  // (o + 0.5) * ratio - 0.5 in signed Q.16, truncated toward zero
  function automatic longint src_position(int o, logic [24:0] ratio);
    longint p17;
    p17 = longint'(2 * o + 1) * longint'({39'd0, ratio}) - 65536;
    return p17 / 2;
  endfunction

  function automatic int tap_weight(longint d);
    longint ad;
    longint ph;
    ad = d < 0 ? -d : d;
    ph = ad >>> 8;
    if (ph >= CoefCount) return 0;
    return lanczos_coef[ph];
  endfunction

  // six-tap pass around position p; each channel clamped to 0..255
  function automatic logic [23:0] lanczos_pass(logic [23:0] px [TapCount], longint p);
    longint      ip, tap;
    int          w, acc [3];
    logic [23:0] pix;
    ip = p / 65536;
    acc = '{0, 0, 0};
    for (int j = 0; j < TapCount; j++) begin
      tap = ip - 2 + j;
      w = tap_weight(p - tap * 65536);
      for (int c = 0; c < 3; c++) acc[c] += (int'(px[j][23 - 8 * c -: 8]) * w) / 16384;
    end
    for (int c = 0; c < 3; c++)
      pix[23 - 8 * c -: 8] = acc[c] < 0 ? 8'd0 : (acc[c] > 255 ? 8'd255 : 8'(acc[c]));
    return pix;
  endfunction

  function automatic l3s_pkg::res_t resample_pixel(int col, int row);
    longint      px_pos, py_pos, ipx, ipy, r, cc;
    int          w, h;
    logic [23:0] taps [TapCount];
    logic [23:0] partial [TapCount];
    logic [23:0] pix;
    w = eff_width();
    h = eff_height();
    px_pos = src_position(col, hratio_reg);
    py_pos = src_position(row, vratio_reg);
    ipx = px_pos / 65536;
    ipy = py_pos / 65536;
    for (int j = 0; j < TapCount; j++) begin
      r = ipy - 2 + j;
      r = r < 0 ? 0 : (r > h - 1 ? h - 1 : r);
      for (int i = 0; i < TapCount; i++) begin
        cc = ipx - 2 + i;
        cc = cc < 0 ? 0 : (cc > w - 1 ? w - 1 : cc);
        taps[i] = frame_mem[(r * w + cc) % 65536];
      end
      partial[j] = lanczos_pass(taps, px_pos);
    end
    pix = lanczos_pass(partial, py_pos);
    return l3s_pkg::res_t'(pix);
  endfunction

  // advance the model by one accepted transfer
  task automatic model_transfer(l3s_pkg::req_t r, bit typed, l3s_pkg::res_t want);
    l3s_pkg::res_t exp_pix;
    if (!r.mode) begin
      frame_mem[load_ptr % 65536] = {r.in_red, r.in_green, r.in_blue};
      load_ptr++;
      if (load_ptr >= eff_width() * eff_height()) load_ptr = 0;
      load_count++;
    end else begin
      exp_pix = resample_pixel(r.out_column, r.out_row);
      pixels_due.push_back(typed ? want : exp_pix);
      req_count++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driving. start_i stays high across back-to-back transfers; it is only
  // lowered for an idle gap, so each step carries one assignment to it.
  // ---------------------------------------------------------------------------
  task automatic send_item(l3s_pkg::req_t r, bit typed, l3s_pkg::res_t want);
    start_i <= 1'b1;
    req_i   <= r;
    forever begin
      @(posedge clk_i);
      if (!busy_o) break;
    end
    model_transfer(r, typed, want);
    if (idle_on && $urandom_range(99) < 8) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  // let every expected pixel arrive, then the block settle
  task automatic wait_idle();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pixels_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // registers are written only while idle (caller has drained); a trailing
  // wait keeps the enable drop and the next raise in separate steps
  task automatic write_reg(logic [1:0] idx, logic [24:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      l3s_pkg::CfgSourceWidth: begin
        width_reg = value[8:0];
        load_ptr = 0;
      end
      l3s_pkg::CfgSourceHeight: begin
        height_reg = value[8:0];
        load_ptr = 0;
      end
      l3s_pkg::CfgHorizRatio: hratio_reg = value;
      default: vratio_reg = value;
    endcase
    cfg_count++;
    @(posedge clk_i);
  endtask

  function automatic l3s_pkg::req_t load_item(logic [23:0] pix);
    l3s_pkg::req_t r;
    r = '0;
    r.mode = 1'b0;
    {r.in_red, r.in_green, r.in_blue} = pix;
    r.out_column = 12'($urandom);
    r.out_row = 12'($urandom);
    return r;
  endfunction

  function automatic l3s_pkg::req_t pixel_item(int col, int row);
    l3s_pkg::req_t r;
    r = '0;
    r.mode = 1'b1;
    {r.in_red, r.in_green, r.in_blue} = 24'($urandom);
    r.out_column = 12'(col);
    r.out_row = 12'(row);
    return r;
  endfunction

  function automatic stim_row_t cfg_row(logic [1:0] idx, logic [24:0] value);
    stim_row_t s;
    s = '0;
    s.kind = RowCfg;
    s.idx = idx;
    s.value = value;
    return s;
  endfunction

  function automatic stim_row_t ld_row(logic [23:0] pix);
    stim_row_t s;
    s = '0;
    s.kind = RowLoad;
    s.req = load_item(pix);
    return s;
  endfunction

  function automatic stim_row_t px_row(int col, int row, bit typed, logic [23:0] want);
    stim_row_t s;
    s = '0;
    s.kind = RowReq;
    s.req = pixel_item(col, row);
    s.typed = typed;
    s.want = l3s_pkg::res_t'(want);
    return s;
  endfunction

  // random register value: extremes, identity, and random spread
  function automatic logic [24:0] pick_ratio();
    case ($urandom_range(9))
      0: return 25'd0;
      1: return 25'h1FFFFFF;
      2: return 25'd16777216;
      3, 4: return 25'd65536;
      5: return 25'($urandom);
      default: return 25'($urandom_range(8192, 262144));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking: every strobe pops the oldest expected pixel.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) begin
      if (pixels_due.size() == 0) begin
        $error("unexpected result %h", res_o);
        err_count++;
      end else begin
        l3s_pkg::res_t want;
        want = pixels_due.pop_front();
        if (res_o.out_red !== want.out_red) begin
          $error("out_red: expected %0d, got %0d", want.out_red, res_o.out_red);
          err_count++;
        end
        if (res_o.out_green !== want.out_green) begin
          $error("out_green: expected %0d, got %0d", want.out_green, res_o.out_green);
          err_count++;
        end
        if (res_o.out_blue !== want.out_blue) begin
          $error("out_blue: expected %0d, got %0d", want.out_blue, res_o.out_blue);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    stim_row_t dir_tab [$];
    int        w, h, nreq, wi, hi, col_span, row_span;

    err_count = 0;
    cycle_count = 0;
    req_count = 0;
    load_count = 0;
    cfg_count = 0;
    idle_on = 1'b1;
    load_ptr = 0;
    width_reg = 9'd256;
    height_reg = 9'd256;
    hratio_reg = 25'd65536;
    vratio_reg = 25'd65536;
    fill_lanczos_coef();

    // 3x2 frame at identity ratio: integer distances have zero weight, so a
    // request returns the source pixel itself; far positions clamp to a corner
    dir_tab = '{
      cfg_row(l3s_pkg::CfgSourceWidth, 25'd3),
      cfg_row(l3s_pkg::CfgSourceHeight, 25'd2),
      cfg_row(l3s_pkg::CfgHorizRatio, 25'd65536),
      cfg_row(l3s_pkg::CfgVertRatio, 25'd65536),
      ld_row(24'h000000), ld_row(24'hFFFFFF), ld_row(24'h5AA55A),
      ld_row(24'hA55AA5), ld_row(24'h0180FE), ld_row(24'hFE7F01),
      px_row(0, 0, 1'b1, 24'h000000),
      px_row(1, 0, 1'b1, 24'hFFFFFF),
      px_row(0, 1, 1'b1, 24'hA55AA5),
      px_row(2, 1, 1'b1, 24'hFE7F01),
      px_row(4095, 4095, 1'b1, 24'hFE7F01),
      px_row(4095, 0, 1'b1, 24'h5AA55A),
      cfg_row(l3s_pkg::CfgHorizRatio, 25'd0),        // zero ratio: position -0.5
      px_row(1, 1, 1'b0, 24'h0),
      cfg_row(l3s_pkg::CfgVertRatio, 25'h1FFFFFF),   // widest ratio field
      px_row(4095, 4095, 1'b0, 24'h0),
      px_row(0, 0, 1'b0, 24'h0),
      cfg_row(l3s_pkg::CfgHorizRatio, 25'd32768),    // 2x upscale, fractional taps
      cfg_row(l3s_pkg::CfgVertRatio, 25'd98304),
      px_row(1, 1, 1'b0, 24'h0),
      px_row(2, 3, 1'b0, 24'h0)
    };

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == RowCfg) begin
        wait_idle();
        write_reg(dir_tab[i].idx, dir_tab[i].value);
      end else begin
        send_item(dir_tab[i].req, dir_tab[i].typed, dir_tab[i].want);
      end
    end

    // random phases: new settings, a full frame load, then mixed traffic
    while (req_count + load_count < RandItems + 27) begin
      wait_idle();   // also the sender pause until every pixel is back
      // a stretch of the run with no idle gaps
      idle_on = !(req_count + load_count > 700 && req_count + load_count < 1100);
      case ($urandom_range(19))
        0: begin wi = 0;   hi = $urandom_range(1, 6); end
        1: begin wi = 511; hi = $urandom_range(1, 2); end
        2: begin wi = 256; hi = 1; end
        3: begin wi = $urandom_range(1, 4); hi = 0; end
        4: begin wi = 1;   hi = 256; end
        5: begin wi = 2;   hi = 300; end
        default: begin wi = $urandom_range(1, 12); hi = $urandom_range(1, 12); end
      endcase
      write_reg(l3s_pkg::CfgSourceWidth, 25'(wi) | (25'($urandom) & 25'h1FFFE00));
      write_reg(l3s_pkg::CfgSourceHeight, 25'(hi) | (25'($urandom) & 25'h1FFFE00));
      write_reg(l3s_pkg::CfgHorizRatio, pick_ratio());
      write_reg(l3s_pkg::CfgVertRatio, pick_ratio());
      w = eff_width();
      h = eff_height();
      for (int k = 0; k < w * h; k++) begin
        case ($urandom_range(15))
          0: send_item(load_item(24'h000000), 1'b0, '0);
          1: send_item(load_item(24'hFFFFFF), 1'b0, '0);
          default: send_item(load_item(24'($urandom)), 1'b0, '0);
        endcase
      end
      // request positions mostly near the frame, sometimes anywhere
      col_span = w + 8;
      row_span = h + 8;
      nreq = $urandom_range(10, 40);
      for (int k = 0; k < nreq; k++) begin
        if ($urandom_range(4) == 0)
          send_item(load_item(24'($urandom)), 1'b0, '0);
        else if ($urandom_range(9) == 0)
          send_item(pixel_item($urandom_range(4095), $urandom_range(4095)), 1'b0, '0);
        else
          send_item(pixel_item($urandom_range(col_span), $urandom_range(row_span)),
                    1'b0, '0);
      end
    end

    wait_idle();
    if (pixels_due.size() != 0) begin
      $error("%0d expected pixels never arrived", pixels_due.size());
      err_count++;
    end
    $display("covered %0d pixel requests and %0d frame loads over %0d register writes,",
             req_count, load_count, cfg_count);
    $display("sizes 1..256 with out-of-range codes, ratios from zero to full scale");
    if (err_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### lanczos3_image_scaler_core.f
sv/l3s_pkg.sv
sv/l3s_ram.sv
sv/l3s_mac.sv
sv/l3s_seq.sv
sv/lanczos3_image_scaler_core.sv
test/testbench.sv
